@@ rtl/lcg_ranged_draw_with_seed_bank_defines.svh @@
// ----------------------------------------------------------------------------
// LCG ranged draw assertion macros
// Shared property wrappers for the generator block; clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCG_RANGED_DRAW_WITH_SEED_BANK_DEFINES_SVH
`define LCG_RANGED_DRAW_WITH_SEED_BANK_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define LRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define LRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lrd_pkg.sv @@
// ----------------------------------------------------------------------------
// LCG ranged draw package
// Constants, stream widths, action codes and the seed bank reset table.
// ----------------------------------------------------------------------------
package lrd_pkg;

    // Generator recurrence X = (LCG_MUL * X + LCG_ADD) mod LCG_MOD
    localparam int unsigned LCG_MUL    = 24298;
    localparam int unsigned LCG_ADD    = 99991;
    localparam int unsigned LCG_MOD    = 199017;
    localparam int unsigned SEED_RESET = 138;

    // Field widths
    localparam int unsigned SEED_W   = 18;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned SPAN_W   = VALUE_W + 1;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned ACTION_W = 2;

    // Seed bank size
    localparam int unsigned NUM_GENERATORS_DEF = 10;
    localparam int unsigned NUM_GENERATORS_MAX = 16;

    // Product width: an 18-bit operand times a 17-bit operand
    localparam int unsigned PROD_W = SEED_W + SPAN_W;

    // Reduction by the modulus through a scaled reciprocal. Every product to
    // reduce stays below 2**RECIP_SHIFT; its top SEED_W bits times RECIP_M,
    // shifted down by SEED_W, give a quotient at most two short, so the
    // remainder left over is below three moduli.
    localparam int unsigned     RECIP_SHIFT = 34;
    localparam int unsigned     RECIP_LSB   = RECIP_SHIFT - SEED_W;
    localparam longint unsigned RECIP_M     = (64'd1 << RECIP_SHIFT) / LCG_MOD;
    localparam int unsigned     QUOT_W      = SPAN_W;
    localparam int unsigned     REM_W       = SEED_W + 2;

    // Stream payload widths
    localparam int unsigned IN_DATA_BITS  = 2 * VALUE_W + SLOT_W + SEED_W;
    localparam int unsigned IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_BITS = VALUE_W + SEED_W;
    localparam int unsigned OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Action codes carried on s_tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_DRAW   = 2'd0,
        ACT_SELECT = 2'd1,
        ACT_SET    = 2'd2
    } action_t;

    // Reset contents of the seed bank; entries past the tenth start at zero
    function automatic logic [SEED_W-1:0] bank_reset(input int unsigned idx);
        logic [SEED_W-1:0] val;
        unique case (idx)
            0:       val = SEED_W'(1197);
            1:       val = SEED_W'(949);
            2:       val = SEED_W'(8384);
            3:       val = SEED_W'(3553);
            4:       val = SEED_W'(3399);
            5:       val = SEED_W'(9880);
            6:       val = SEED_W'(1134);
            7:       val = SEED_W'(6543);
            8:       val = SEED_W'(9988);
            9:       val = SEED_W'(88776);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/lcg_ranged_draw_with_seed_bank.sv @@
// ----------------------------------------------------------------------------
// LCG ranged draw with seed bank
// Linear congruential generator with a bank of saved seeds, drawing values
// scaled onto an inclusive range through one shared multiplier.
// ----------------------------------------------------------------------------
// A draw steps through its states in order: a multiply forms the recurrence
// product and three more steps reduce it by the modulus (a reciprocal
// multiply for a quotient estimate, a multiply back for the remainder, and
// one correction of up to two moduli); the same four steps scale the state
// onto the range, a done state loads the result and the block then returns
// to idle. All multiplies share one 18 by 17 bit multiplier. A draw result
// not taken holds the block until the output register drains. Select and
// set complete in the transfer cycle; their result is valid the cycle
// after, and the next item is taken as soon as the output register is free
// or drained. Seed bank reset values load at reset; no clearing pass is
// needed.
`include "lcg_ranged_draw_with_seed_bank_defines.svh"

module lcg_ranged_draw_with_seed_bank #(
    parameter int unsigned NUM_GENERATORS = lrd_pkg::NUM_GENERATORS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // range_low[15:0], range_high[31:16], slot[35:32], new_seed[53:36]
    input  logic [lrd_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [lrd_pkg::ACTION_W-1:0]      s_tuser,
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // drawn_value[15:0], seed_now[33:16]
    output logic [lrd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    import lrd_pkg::*;

    localparam int unsigned IDX_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_MUL_SCALE,
        ST_RECIP,
        ST_BACK,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [SEED_W-1:0]       seed_reg;
    logic [SEED_W-1:0]       bank_reg [NUM_GENERATORS];
    logic [IDX_W-1:0]        cur_slot_reg;
    logic [VALUE_W-1:0]      lo_reg;
    logic                    empty_reg;
    logic [SPAN_W-1:0]       span_reg;
    logic                    scale_pass_reg;
    logic [RECIP_SHIFT-1:0]  num_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [REM_W-1:0]        rem_reg;
    logic                    out_valid_reg;
    logic [VALUE_W-1:0]      out_drawn_reg;
    logic [SEED_W-1:0]       out_seed_reg;

    logic [PROD_W-1:0]       prod;
    logic [SEED_W-1:0]       mul_a;
    logic [SPAN_W-1:0]       mul_b;
    logic [PROD_W-1:0]       mul_c;
    logic [SEED_W-1:0]       fix_rem;
    logic [QUOT_W-1:0]       fix_quot;

    // Unpack the input transfer
    action_t                 in_action;
    logic [VALUE_W-1:0]      in_lo;
    logic [VALUE_W-1:0]      in_hi;
    logic [SLOT_W-1:0]       in_slot;
    logic [SEED_W-1:0]       in_seed;
    logic [IDX_W-1:0]        sel_idx;
    logic                    sel_ok;
    logic [SEED_W-1:0]       sel_seed;
    logic                    out_free;
    logic                    in_fire;
    logic                    out_load;

    assign in_action = action_t'(s_tuser);
    assign in_lo     = s_tdata[VALUE_W-1:0];
    assign in_hi     = s_tdata[2*VALUE_W-1:VALUE_W];
    assign in_slot   = s_tdata[2*VALUE_W+SLOT_W-1:2*VALUE_W];
    assign in_seed   = s_tdata[2*VALUE_W+SLOT_W+SEED_W-1:2*VALUE_W+SLOT_W];

    assign sel_idx  = IDX_W'(in_slot);
    assign sel_ok   = ({1'b0, in_slot} < (SLOT_W+1)'(NUM_GENERATORS));
    // A select of the current slot reloads the seed just stored
    assign sel_seed = (sel_idx == cur_slot_reg) ? seed_reg : bank_reg[sel_idx];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // Results of select, set and unused actions load at once, draws when done
    assign out_load = (in_fire && (in_action != ACT_DRAW))
                   || ((state_reg == ST_DONE) && out_free);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_seed_reg, out_drawn_reg});

    // Shared multiplier: recurrence step, scale by the span, reciprocal
    // estimate of the quotient, or quotient back times the modulus
    always_comb
    begin
        case (state_reg)
            ST_MUL_STEP:
            begin
                mul_a = seed_reg;
                mul_b = SPAN_W'(LCG_MUL);
                mul_c = PROD_W'(LCG_ADD);
            end
            ST_RECIP:
            begin
                mul_a = num_reg[RECIP_LSB +: SEED_W];
                mul_b = SPAN_W'(RECIP_M);
                mul_c = '0;
            end
            ST_BACK:
            begin
                mul_a = SEED_W'(LCG_MOD);
                mul_b = quot_reg;
                mul_c = '0;
            end
            default:
            begin
                mul_a = seed_reg;
                mul_b = span_reg;
                mul_c = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b) + mul_c;

    // Correct the estimate: the remainder holds up to two extra moduli
    always_comb
    begin
        if (rem_reg >= REM_W'(2 * LCG_MOD))
        begin
            fix_rem  = SEED_W'(rem_reg - REM_W'(2 * LCG_MOD));
            fix_quot = quot_reg + QUOT_W'(2);
        end
        else if (rem_reg >= REM_W'(LCG_MOD))
        begin
            fix_rem  = SEED_W'(rem_reg - REM_W'(LCG_MOD));
            fix_quot = quot_reg + QUOT_W'(1);
        end
        else
        begin
            fix_rem  = SEED_W'(rem_reg);
            fix_quot = quot_reg;
        end
    end

    // Sequencer, generator state, seed bank and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seed_reg       <= SEED_W'(SEED_RESET);
            for (int i = 0; i < NUM_GENERATORS; i++)
            begin
                bank_reg[i] <= bank_reset(i);
            end
            cur_slot_reg   <= '0;
            lo_reg         <= '0;
            empty_reg      <= 1'b0;
            span_reg       <= '0;
            scale_pass_reg <= 1'b0;
            num_reg        <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_drawn_reg  <= '0;
            out_seed_reg   <= '0;
        end
        else
        begin
            // Load a finished result, drop it once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_action)
                            ACT_DRAW:
                            begin
                                lo_reg    <= in_lo;
                                empty_reg <= (in_hi < in_lo);
                                // Zero span on an empty range keeps the product small
                                span_reg  <= (in_hi < in_lo) ? '0
                                           : SPAN_W'({1'b0, in_hi} - {1'b0, in_lo} + 1'b1);
                                state_reg <= ST_MUL_STEP;
                            end
                            ACT_SELECT:
                            begin
                                out_drawn_reg <= '0;
                                if (sel_ok)
                                begin
                                    bank_reg[cur_slot_reg] <= seed_reg;
                                    seed_reg               <= sel_seed;
                                    cur_slot_reg           <= sel_idx;
                                    out_seed_reg           <= sel_seed;
                                end
                                else
                                begin
                                    out_seed_reg <= seed_reg;
                                end
                            end
                            ACT_SET:
                            begin
                                seed_reg      <= in_seed;
                                out_drawn_reg <= '0;
                                out_seed_reg  <= in_seed;
                            end
                            default:
                            begin
                                out_drawn_reg <= '0;
                                out_seed_reg  <= seed_reg;
                            end
                        endcase
                    end
                end

                ST_MUL_STEP, ST_MUL_SCALE:
                begin
                    num_reg        <= prod[RECIP_SHIFT-1:0];
                    scale_pass_reg <= (state_reg == ST_MUL_SCALE);
                    state_reg      <= ST_RECIP;
                end

                ST_RECIP:
                begin
                    // Quotient estimate sits SEED_W bits up in the product
                    quot_reg  <= prod[SEED_W +: QUOT_W];
                    state_reg <= ST_BACK;
                end

                ST_BACK:
                begin
                    // Remainder fits the low bits, so subtract only those
                    rem_reg   <= num_reg[REM_W-1:0] - prod[REM_W-1:0];
                    state_reg <= ST_FIX;
                end

                ST_FIX:
                begin
                    if (!scale_pass_reg)
                    begin
                        // Remainder is the advanced generator state
                        seed_reg  <= fix_rem;
                        state_reg <= ST_MUL_SCALE;
                    end
                    else
                    begin
                        // Quotient is the offset into the range
                        out_drawn_reg <= empty_reg ? lo_reg
                                                   : lo_reg + fix_quot[VALUE_W-1:0];
                        state_reg     <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // Hold the draw until the output register is free
                    if (out_free)
                    begin
                        out_seed_reg <= seed_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Advanced state always lands below the modulus
    `LRD_ASSERT_NEXT(a_seed_reduced,
        (state_reg == ST_FIX) && !scale_pass_reg,
        seed_reg < SEED_W'(LCG_MOD),
        "advanced generator state not reduced by the modulus")

    // Quotient estimate leaves less than three moduli over
    `LRD_ASSERT_NOW(a_rem_bounded,
        state_reg == ST_FIX,
        rem_reg < REM_W'(3 * LCG_MOD),
        "quotient estimate too far below the true quotient")

    // Scaled offset stays inside the span
    `LRD_ASSERT_NOW(a_offset_in_span,
        (state_reg == ST_FIX) && scale_pass_reg && !empty_reg,
        fix_quot < span_reg,
        "scaled offset outside the requested range")

    // No input taken while a draw is in flight
    `LRD_ASSERT_NOW(a_busy_not_ready,
        state_reg != ST_IDLE,
        !s_tready,
        "input accepted while a draw is in progress")

    // Current slot always names a bank entry
    `LRD_ASSERT_NOW(a_slot_in_bank,
        1'b1,
        {1'b0, cur_slot_reg} < (IDX_W+1)'(NUM_GENERATORS),
        "current slot outside the seed bank")

    // A draw result is presented the cycle after it completes
    `LRD_ASSERT_NEXT(a_draw_presented,
        (state_reg == ST_DONE) && out_free,
        m_tvalid && (state_reg == ST_IDLE),
        "finished draw not presented on the output")

endmodule
